// ----- sv/bpgn_pkg.sv -----
package bpgn_pkg;

   // Field widths of the command and result items
   localparam int OP_W    = 3;
   localparam int WIDX_W  = 2;
   localparam int VAR_W   = 10;
   localparam int LANE_W  = 64;

   // Default sizing of the value memory
   localparam int NUM_VARS_DEF = 1024;
   localparam int WORDS_DEF    = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
   localparam logic [OP_W-1:0] OP_AND      = 3'd1;
   localparam logic [OP_W-1:0] OP_XOR      = 3'd2;
   localparam logic [OP_W-1:0] OP_CLAUSE   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ     = 3'd4;
   localparam logic [OP_W-1:0] OP_SETVALID = 3'd5;

   // Controller to datapath
   typedef struct packed {
      logic load;   // capture the accepted item
      logic rd1;    // first memory read phase
      logic rd2;    // second read phase (gates only: old row)
      logic exec;   // compute, store, emit result
   } bpgn_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_gate;
   } bpgn_stat_type;

endpackage

// ----- sv/bpgn_ctrl.sv -----
module bpgn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bpgn_pkg::bpgn_stat_type stat,
   output bpgn_pkg::bpgn_cmd_type  cmd
);
   import bpgn_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD1  = 2'd1;
   localparam logic [1:0] ST_RD2  = 2'd2;
   localparam logic [1:0] ST_EXEC = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = stat.is_gate ? ST_RD2 : ST_EXEC;
         end
         ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_accept_to_rd1: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_RD1))
      else $error("accepted item did not enter first read phase");

   a_rd2_only_gate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD2) |-> stat.is_gate)
      else $error("second read phase on a non-gate item");

   a_rd2_after_rd1: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD2) |-> ($past(state_ff) == ST_RD1))
      else $error("second read phase not preceded by first");

   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_IDLE))
      else $error("execute phase did not return to idle");

endmodule

// ----- sv/bpgn_datapath.sv -----
module bpgn_datapath #(
   parameter int NUM_VARS = bpgn_pkg::NUM_VARS_DEF,
   parameter int WORDS    = bpgn_pkg::WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bpgn_pkg::bpgn_cmd_type          cmd,
   output bpgn_pkg::bpgn_stat_type         stat,
   input  logic [bpgn_pkg::OP_W-1:0]       req_operation,
   input  logic [bpgn_pkg::WIDX_W-1:0]     req_word_index,
   input  logic [bpgn_pkg::VAR_W-1:0]      req_out_var,
   input  logic [bpgn_pkg::VAR_W-1:0]      req_in_a_var,
   input  logic                            req_in_a_neg,
   input  logic [bpgn_pkg::VAR_W-1:0]      req_in_b_var,
   input  logic                            req_in_b_neg,
   input  logic                            req_out_neg,
   input  logic [bpgn_pkg::LANE_W-1:0]     req_lane_mask,
   input  logic [bpgn_pkg::LANE_W-1:0]     req_data_word,
   input  logic                            req_clause_last,
   output logic                            rsp_valid,
   output logic [bpgn_pkg::LANE_W-1:0]     rsp_result_word,
   output logic                            rsp_clause_done
);
   import bpgn_pkg::*;

   localparam int DEPTH  = NUM_VARS * WORDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int VIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   // Latched item
   logic [OP_W-1:0]   op_ff;
   logic [WIDX_W-1:0] word_ff;
   logic [VAR_W-1:0]  out_var_ff;
   logic [VAR_W-1:0]  a_var_ff;
   logic              a_neg_ff;
   logic [VAR_W-1:0]  b_var_ff;
   logic              b_neg_ff;
   logic              out_neg_ff;
   logic [LANE_W-1:0] mask_ff;
   logic [LANE_W-1:0] data_ff;
   logic              last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_operation;
         word_ff    <= req_word_index;
         out_var_ff <= req_out_var;
         a_var_ff   <= req_in_a_var;
         a_neg_ff   <= req_in_a_neg;
         b_var_ff   <= req_in_b_var;
         b_neg_ff   <= req_in_b_neg;
         out_neg_ff <= req_out_neg;
         mask_ff    <= req_lane_mask;
         data_ff    <= req_data_word;
         last_ff    <= req_clause_last;
      end
   end

   logic is_gate;
   assign is_gate      = (op_ff == OP_AND) || (op_ff == OP_XOR);
   assign stat.is_gate = is_gate;

   // Range checks and row addresses
   logic w_ok, a_ok, b_ok, o_ok;
   logic [ADDR_W-1:0] a_addr, b_addr, o_addr;

   assign w_ok = (32'(word_ff) < WORDS);
   assign a_ok = w_ok && (32'(a_var_ff)   < NUM_VARS);
   assign b_ok = w_ok && (32'(b_var_ff)   < NUM_VARS);
   assign o_ok = w_ok && (32'(out_var_ff) < NUM_VARS);

   assign a_addr = ADDR_W'(32'(a_var_ff)   * 32'(WORDS) + 32'(word_ff));
   assign b_addr = ADDR_W'(32'(b_var_ff)   * 32'(WORDS) + 32'(word_ff));
   assign o_addr = ADDR_W'(32'(out_var_ff) * 32'(WORDS) + 32'(word_ff));

   // Value memory: two read ports, one write port
   logic [LANE_W-1:0] var_mem [DEPTH];
   logic [LANE_W-1:0] rd0_ff, rd1_ff, a_ff;
   logic              rd0_en, rd1_en, wr_en;
   logic [ADDR_W-1:0] rd0_addr;
   logic [LANE_W-1:0] wr_data;

   assign rd0_en   = cmd.rd1 || cmd.rd2;
   assign rd1_en   = cmd.rd1 && is_gate;
   assign rd0_addr = (cmd.rd1 && (is_gate || op_ff == OP_CLAUSE)) ? a_addr : o_addr;

   always_ff @(posedge clock) begin
      if (rd0_en) begin
         rd0_ff <= var_mem[rd0_addr];
      end
      if (rd1_en) begin
         rd1_ff <= var_mem[b_addr];
      end
      if (cmd.rd2) begin
         a_ff <= rd0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         var_mem[o_addr] <= wr_data;
      end
   end

   // Valid words and clause accumulator
   logic [LANE_W-1:0] valid_ff [WORDS];
   logic [LANE_W-1:0] acc_ff, acc_in;
   logic              valid_we;
   logic [LANE_W-1:0] valid_wdata;
   logic [VIDX_W-1:0] vidx;
   logic [LANE_W-1:0] valid_cur;

   assign vidx      = VIDX_W'(word_ff);
   assign valid_cur = w_ok ? valid_ff[vidx] : '0;

   // Execute
   logic [LANE_W-1:0] a_val, b_val, old_val, f_val, merged;
   logic [LANE_W-1:0] na, nb, no, lit_or;
   logic [LANE_W-1:0] res_in;
   logic              done_in;

   always_comb begin
      a_val   = a_ok ? (is_gate ? a_ff : rd0_ff) : '0;
      b_val   = b_ok ? rd1_ff : '0;
      old_val = o_ok ? rd0_ff : '0;
      na      = {LANE_W{a_neg_ff}};
      nb      = {LANE_W{b_neg_ff}};
      no      = {LANE_W{out_neg_ff}};
      lit_or  = acc_ff | (a_val ^ na);
      if (op_ff == OP_AND) begin
         f_val = ((a_val ^ na) & (b_val ^ nb)) ^ no;
      end else begin
         f_val = a_val ^ b_val ^ (na ^ nb ^ no);
      end

      wr_en       = 1'b0;
      wr_data     = '0;
      valid_we    = 1'b0;
      valid_wdata = '0;
      acc_in      = acc_ff;
      res_in      = '0;
      done_in     = 1'b0;
      merged      = '0;

      unique case (op_ff)
         OP_WRITE: begin
            wr_en   = cmd.exec && o_ok;
            wr_data = (old_val & ~mask_ff) | (data_ff & mask_ff);
         end
         OP_AND, OP_XOR: begin
            merged  = (old_val & ~mask_ff) | (f_val & mask_ff);
            wr_en   = cmd.exec && o_ok;
            wr_data = merged;
            res_in  = merged;
         end
         OP_CLAUSE: begin
            if (last_ff) begin
               acc_in = '0;
               if (w_ok) begin
                  valid_we    = 1'b1;
                  valid_wdata = valid_cur & lit_or;
                  res_in      = valid_cur & lit_or;
                  done_in     = 1'b1;
               end
            end else begin
               acc_in = lit_or;
            end
         end
         OP_READ: begin
            res_in = old_val;
         end
         OP_SETVALID: begin
            valid_we    = w_ok;
            valid_wdata = data_ff;
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            valid_ff[i] <= '0;
         end
         acc_ff <= '0;
      end else if (cmd.exec) begin
         if (valid_we) begin
            valid_ff[vidx] <= valid_wdata;
         end
         acc_ff <= acc_in;
      end
   end

   // Result register
   logic              rsp_valid_ff;
   logic [LANE_W-1:0] rsp_word_ff;
   logic              rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_word_ff <= res_in;
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;
   assign rsp_clause_done = rsp_done_ff;

endmodule

// ----- sv/bit_parallel_gate_network_sim.sv -----
// Bit-parallel gate network evaluator, 64 lanes per word.
// Command channel: drive req_* and raise start; the item is taken at the
// rising edge where start is high and busy is low. busy stays high until
// the item's result has been produced.
// Result channel: exactly one result per item. rsp_valid is high for one
// cycle with rsp_result_word and rsp_clause_done; the receiver must take it
// then, there is no back pressure.
// Sequence: write, clause literal, read, set valid word and unused codes
// pass the first read phase and the execute phase, after which the result
// is registered onto the ports; AND and XOR gates add a second read phase,
// since the two-read-port value memory needs a second read for the old
// destination row. A new item may be accepted in the same cycle the
// previous result is shown, not before; the read phases set the pace.
// Reset: valid words and clause accumulator clear at once; the value memory
// is not cleared and must be written before a row is read.
module bit_parallel_gate_network_sim #(
   parameter int NUM_VARS = bpgn_pkg::NUM_VARS_DEF,
   parameter int WORDS    = bpgn_pkg::WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bpgn_pkg::OP_W-1:0]       req_operation,
   input  logic [bpgn_pkg::WIDX_W-1:0]     req_word_index,
   input  logic [bpgn_pkg::VAR_W-1:0]      req_out_var,
   input  logic [bpgn_pkg::VAR_W-1:0]      req_in_a_var,
   input  logic                            req_in_a_neg,
   input  logic [bpgn_pkg::VAR_W-1:0]      req_in_b_var,
   input  logic                            req_in_b_neg,
   input  logic                            req_out_neg,
   input  logic [bpgn_pkg::LANE_W-1:0]     req_lane_mask,
   input  logic [bpgn_pkg::LANE_W-1:0]     req_data_word,
   input  logic                            req_clause_last,
   output logic                            rsp_valid,
   output logic [bpgn_pkg::LANE_W-1:0]     rsp_result_word,
   output logic                            rsp_clause_done
);
   import bpgn_pkg::*;

   // Command and status between sequencer and datapath
   bpgn_cmd_type  cmd;
   bpgn_stat_type stat;

   // Sequencer: idle, first read, optional second read, execute
   bpgn_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath: item latch, value memory, valid words, accumulator, result
   bpgn_datapath #(
      .NUM_VARS (NUM_VARS),
      .WORDS    (WORDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_word_index  (req_word_index),
      .req_out_var     (req_out_var),
      .req_in_a_var    (req_in_a_var),
      .req_in_a_neg    (req_in_a_neg),
      .req_in_b_var    (req_in_b_var),
      .req_in_b_neg    (req_in_b_neg),
      .req_out_neg     (req_out_neg),
      .req_lane_mask   (req_lane_mask),
      .req_data_word   (req_data_word),
      .req_clause_last (req_clause_last),
      .rsp_valid       (rsp_valid),
      .rsp_result_word (rsp_result_word),
      .rsp_clause_done (rsp_clause_done)
   );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpgn_pkg::*;

   // Memory geometry follows the block's default sizing.
   localparam int ROWS = NUM_VARS_DEF * WORDS_DEF;

   // Codes the block has no use for; they must come back as an empty result.
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   localparam logic [LANE_W-1:0] ALL_LANES = '1;
   localparam logic [LANE_W-1:0] NO_LANES  = '0;

   localparam int RANDOM_ITEMS = 700;
   localparam int QUIET_TAIL   = 100;     // last items go out back to back
   localparam int DRAIN_EVERY  = 150;     // pause until empty this often
   localparam int SETTLE       = 12;      // cycles after the last result
   localparam int CYCLE_LIMIT  = 500000;  // a hung run is stopped at this count
   localparam int POOL         = 12;      // variables most items work on

   // One command item, field by field.
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [WIDX_W-1:0] widx;
      logic [VAR_W-1:0]  ov;
      logic [VAR_W-1:0]  av;
      logic              an;
      logic [VAR_W-1:0]  bv;
      logic              bn;
      logic              on;
      logic [LANE_W-1:0] mask;
      logic [LANE_W-1:0] data;
      logic              last;
   } gate_cmd_type;

   // One result item.
   typedef struct {
      logic [LANE_W-1:0] word;
      logic              done;
   } gate_rsp_type;

   // One row of the directed table; typed rows carry their own answer.
   typedef struct {
      gate_cmd_type cmd;
      bit           typed;
      gate_rsp_type rsp;
   } gate_step_type;

   // ---------------------------------------------------------------------
   // Block ports
   // ---------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation   = '0;
   logic [WIDX_W-1:0]   req_word_index  = '0;
   logic [VAR_W-1:0]    req_out_var     = '0;
   logic [VAR_W-1:0]    req_in_a_var    = '0;
   logic                req_in_a_neg    = 1'b0;
   logic [VAR_W-1:0]    req_in_b_var    = '0;
   logic                req_in_b_neg    = 1'b0;
   logic                req_out_neg     = 1'b0;
   logic [LANE_W-1:0]   req_lane_mask   = '0;
   logic [LANE_W-1:0]   req_data_word   = '0;
   logic                req_clause_last = 1'b0;
   logic                rsp_valid;
   logic [LANE_W-1:0]   rsp_result_word;
   logic                rsp_clause_done;

   // ---------------------------------------------------------------------
   // Predictor state: lane rows, which lanes of each row hold defined data,
   // the valid words and the running clause sum.
   // ---------------------------------------------------------------------
   logic [LANE_W-1:0] lane_rows   [ROWS];
   logic [LANE_W-1:0] lane_known  [ROWS];
   logic [LANE_W-1:0] valid_words [WORDS_DEF];
   logic [LANE_W-1:0] clause_sum;

   gate_rsp_type      pending_results [$];
   gate_step_type     directed_steps  [$];
   logic [VAR_W-1:0]  var_pool [POOL];
   int                error_count = 0;
   int                cycle_count = 0;

   bit_parallel_gate_network_sim DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_word_index  (req_word_index),
      .req_out_var     (req_out_var),
      .req_in_a_var    (req_in_a_var),
      .req_in_a_neg    (req_in_a_neg),
      .req_in_b_var    (req_in_b_var),
      .req_in_b_neg    (req_in_b_neg),
      .req_out_neg     (req_out_neg),
      .req_lane_mask   (req_lane_mask),
      .req_data_word   (req_data_word),
      .req_clause_last (req_clause_last),
      .rsp_valid       (rsp_valid),
      .rsp_result_word (rsp_result_word),
      .rsp_clause_done (rsp_clause_done)
   );

   // 100 MHz clock.
   always #5ns clock = ~clock;

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------
   function automatic int row_addr(logic [VAR_W-1:0] v, logic [WIDX_W-1:0] w);
      return int'(v) * WORDS_DEF + int'(w);
   endfunction

   // A row may be read only once every one of its lanes has been written.
   function automatic bit row_full(logic [VAR_W-1:0] v, logic [WIDX_W-1:0] w);
      return lane_known[row_addr(v, w)] == ALL_LANES;
   endfunction

   function automatic gate_cmd_type make_cmd(
      logic [OP_W-1:0] op, logic [WIDX_W-1:0] widx, logic [VAR_W-1:0] ov,
      logic [VAR_W-1:0] av, logic an, logic [VAR_W-1:0] bv, logic bn,
      logic on, logic [LANE_W-1:0] mask, logic [LANE_W-1:0] data, logic last);
      gate_cmd_type c;
      c.op = op;     c.widx = widx; c.ov = ov;
      c.av = av;     c.an = an;     c.bv = bv;
      c.bn = bn;     c.on = on;     c.mask = mask;
      c.data = data; c.last = last;
      return c;
   endfunction

   function automatic gate_rsp_type make_rsp(logic [LANE_W-1:0] word, logic done);
      gate_rsp_type r;
      r.word = word;
      r.done = done;
      return r;
   endfunction

   // Append one row to the directed table.
   function automatic void add_step(gate_step_type s);
      directed_steps.insert(directed_steps.size(), s);
   endfunction

   function automatic logic [LANE_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Favor full and empty masks now and then; otherwise scatter lanes.
   function automatic logic [LANE_W-1:0] random_mask();
      int r;
      r = $urandom_range(0, 15);
      if (r < 3)
         return ALL_LANES;
      if (r == 3)
         return NO_LANES;
      return random_word();
   endfunction

   // Mostly the working pool, so rows get reused; sometimes anywhere.
   function automatic logic [VAR_W-1:0] pick_var();
      if ($urandom_range(0, 9) == 0)
         return VAR_W'($urandom_range(0, NUM_VARS_DEF - 1));
      return var_pool[$urandom_range(0, POOL - 1)];
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: apply one accepted item to the shadow state and return the
   // result it must produce.
   // ---------------------------------------------------------------------
   function automatic gate_rsp_type evaluate_command(gate_cmd_type c);
      gate_rsp_type      r;
      logic [LANE_W-1:0] a, b, old, f, na, nb, no;
      int                ai, bi, oi;
      r  = make_rsp(NO_LANES, 1'b0);
      ai = row_addr(c.av, c.widx);
      bi = row_addr(c.bv, c.widx);
      oi = row_addr(c.ov, c.widx);
      na = {LANE_W{c.an}};
      nb = {LANE_W{c.bn}};
      no = {LANE_W{c.on}};
      case (c.op)
         OP_WRITE: begin
            lane_rows[oi]  = (lane_rows[oi] & ~c.mask) | (c.data & c.mask);
            lane_known[oi] = lane_known[oi] | c.mask;
         end
         OP_AND, OP_XOR: begin
            // Read both inputs and the old row before storing (aliasing).
            a   = lane_rows[ai];
            b   = lane_rows[bi];
            old = lane_rows[oi];
            if (c.op == OP_AND)
               f = ((a ^ na) & (b ^ nb)) ^ no;
            else
               f = a ^ b ^ na ^ nb ^ no;
            r.word         = (old & ~c.mask) | (f & c.mask);
            lane_rows[oi]  = r.word;
            lane_known[oi] = lane_known[oi] | c.mask;
         end
         OP_CLAUSE: begin
            clause_sum = clause_sum | (lane_rows[ai] ^ na);
            if (c.last) begin
               valid_words[c.widx] = valid_words[c.widx] & clause_sum;
               r.word     = valid_words[c.widx];
               r.done     = 1'b1;
               clause_sum = NO_LANES;
            end
         end
         OP_READ:
            r.word = lane_rows[oi];
         OP_SETVALID:
            valid_words[c.widx] = c.data;
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver. Entered at a falling edge: put the item on the ports, raise
   // start, and hold until a rising edge sees busy low. Predict right at the
   // accepting edge, then step to the next falling edge with start still
   // high, so a following item just replaces the fields.
   // ---------------------------------------------------------------------
   task automatic send_command(input gate_cmd_type c, input bit typed,
                               input gate_rsp_type typed_rsp);
      gate_rsp_type predicted;
      req_operation   = c.op;
      req_word_index  = c.widx;
      req_out_var     = c.ov;
      req_in_a_var    = c.av;
      req_in_a_neg    = c.an;
      req_in_b_var    = c.bv;
      req_in_b_neg    = c.bn;
      req_out_neg     = c.on;
      req_lane_mask   = c.mask;
      req_data_word   = c.data;
      req_clause_last = c.last;
      start           = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      predicted = evaluate_command(c);
      pending_results.insert(pending_results.size(), typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // Drop start and scramble the fields so the block must ignore them
   // while start is low.
   task automatic hold_off(input int n);
      start           = 1'b0;
      req_operation   = OP_W'($urandom);
      req_word_index  = WIDX_W'($urandom);
      req_out_var     = VAR_W'($urandom);
      req_in_a_var    = VAR_W'($urandom);
      req_in_b_var    = VAR_W'($urandom);
      req_lane_mask   = random_word();
      req_data_word   = random_word();
      req_clause_last = 1'(($urandom));
      repeat (n) @(negedge clock);
   endtask

   // Drop start and wait until every predicted result has come back.
   task automatic wait_drained();
      start = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result checker. Sample at the rising edge, so the values seen are the
   // ones that stood during the cycle that edge closes.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      gate_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("rsp_valid with no item outstanding: result %h, clause_done %b",
                   rsp_result_word, rsp_clause_done);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_word !== want.word) begin
               $error("rsp_result_word: expected %h, got %h", want.word, rsp_result_word);
               error_count++;
            end
            if (rsp_clause_done !== want.done) begin
               $error("rsp_clause_done: expected %b, got %b", want.done, rsp_clause_done);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      gate_cmd_type     c;
      gate_rsp_type     none;
      gate_step_type    s;
      int               r;
      int               clause_left;
      int               saved_left;
      logic [WIDX_W-1:0] clause_word;
      logic [VAR_W-1:0] fix_var;
      bit               need_fix;
      bit               quiet;

      none        = make_rsp(NO_LANES, 1'b0);
      clause_left = 0;
      clause_word = '0;
      clause_sum  = NO_LANES;
      for (int i = 0; i < ROWS; i++)
         lane_known[i] = NO_LANES;
      for (int i = 0; i < WORDS_DEF; i++)
         valid_words[i] = NO_LANES;

      // Pool: the extremes and both alternating patterns, then random picks.
      var_pool[0] = '0;
      var_pool[1] = '1;
      var_pool[2] = 10'h155;
      var_pool[3] = 10'h2AA;
      for (int i = 4; i < POOL; i++)
         var_pool[i] = VAR_W'($urandom_range(0, NUM_VARS_DEF - 1));

      // Hold reset, then release it between edges.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed table --------------------------------------------
      // Fill the valid words, write rows at the variable extremes, try
      // partial and empty masks, a gate whose output aliases an input,
      // fully inverted gates, clauses that end with all lanes and with
      // none, and the two unused codes.
      add_step('{make_cmd(OP_SETVALID, 2'd0, '0, '0, 0, '0, 0, 0,
         NO_LANES, ALL_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_SETVALID, 2'd3, '0, '0, 0, '0, 0, 0,
         NO_LANES, 64'hAAAA_AAAA_AAAA_AAAA, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_WRITE, 2'd0, 10'd0, '0, 0, '0, 0, 0,
         ALL_LANES, ALL_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_WRITE, 2'd0, 10'd1023, '0, 0, '0, 0, 0,
         ALL_LANES, NO_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_READ, 2'd0, 10'd0, '0, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 0), 1'b1, make_rsp(ALL_LANES, 1'b0)});
      add_step('{make_cmd(OP_READ, 2'd0, 10'd1023, '0, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_WRITE, 2'd0, 10'd0, '0, 0, '0, 0, 0,
         64'hFFFF_0000_0000_FFFF, NO_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_READ, 2'd0, 10'd0, '0, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 0), 1'b1, make_rsp(64'h0000_FFFF_FFFF_0000, 1'b0)});
      add_step('{make_cmd(OP_WRITE, 2'd3, 10'h155, '0, 0, '0, 0, 0,
         ALL_LANES, 64'h0123_4567_89AB_CDEF, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_WRITE, 2'd3, 10'h2AA, '0, 0, '0, 0, 0,
         ALL_LANES, 64'hFEDC_BA98_7654_3210, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      // Empty mask: nothing is stored, the row stays unwritten.
      add_step('{make_cmd(OP_WRITE, 2'd3, 10'd0, '0, 0, '0, 0, 0,
         NO_LANES, ALL_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      // Output aliases the first input.
      add_step('{make_cmd(OP_AND, 2'd3, 10'h155, 10'h155, 0, 10'h2AA,
         0, 0, ALL_LANES, NO_LANES, 0), 1'b0, none});
      add_step('{make_cmd(OP_XOR, 2'd3, 10'h2AA, 10'h155, 1, 10'h2AA,
         1, 1, 64'h00FF_00FF_00FF_00FF, NO_LANES, 0), 1'b0, none});
      add_step('{make_cmd(OP_AND, 2'd0, 10'd1023, 10'd0, 1, 10'd1023,
         1, 1, ALL_LANES, NO_LANES, 0), 1'b0, none});
      // A row XORed with itself clears every lane.
      add_step('{make_cmd(OP_XOR, 2'd0, 10'd0, 10'd0, 0, 10'd0, 0, 0,
         ALL_LANES, NO_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_CLAUSE, 2'd0, '0, 10'd0, 1, '0, 0, 0,
         NO_LANES, NO_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_CLAUSE, 2'd0, '0, 10'd1023, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 1), 1'b0, none});
      add_step('{make_cmd(OP_CLAUSE, 2'd3, '0, 10'h155, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 1), 1'b0, none});
      add_step('{make_cmd(OP_SETVALID, 2'd0, '0, '0, 0, '0, 0, 0,
         NO_LANES, ALL_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      // One-literal clause over an all-zero row empties the valid word.
      add_step('{make_cmd(OP_CLAUSE, 2'd0, '0, 10'd0, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 1), 1'b1, make_rsp(NO_LANES, 1'b1)});
      add_step('{make_cmd(OP_SPARE6, 2'd3, '1, '1, 1, '1, 1, 1,
         ALL_LANES, ALL_LANES, 1), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_SPARE7, 2'd3, '1, '1, 1, '1, 1, 1,
         ALL_LANES, ALL_LANES, 1), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_READ, 2'd3, 10'h2AA, '0, 0, '0, 0, 0,
         NO_LANES, NO_LANES, 0), 1'b0, none});
      add_step('{make_cmd(OP_CLAUSE, 2'd3, '0, 10'h2AA, 1, '0, 0, 0,
         NO_LANES, NO_LANES, 0), 1'b1, make_rsp(NO_LANES, 1'b0)});
      add_step('{make_cmd(OP_CLAUSE, 2'd3, '0, 10'h155, 1, '0, 0, 0,
         NO_LANES, NO_LANES, 1), 1'b0, none});

      foreach (directed_steps[i]) begin
         s = directed_steps[i];
         send_command(s.cmd, s.typed, s.rsp);
         if ($urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 18));
      end

      // Let the directed items drain before the random part starts.
      wait_drained();

      // ---- random part -----------------------------------------------
      // Mostly gates and well-formed clauses (a run of literals on one
      // word, the last one marked), with writes, reads, valid-word loads,
      // stray literals and unused codes mixed in.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         c = make_cmd(OP_WRITE, WIDX_W'($urandom_range(0, WORDS_DEF - 1)), pick_var(),
                      pick_var(), 1'($urandom_range(0, 1)), pick_var(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      random_mask(), random_word(), 1'($urandom_range(0, 1)));
         saved_left = clause_left;
         if (clause_left > 0) begin
            c.op   = OP_CLAUSE;
            c.widx = clause_word;
            clause_left--;
            c.last = (clause_left == 0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12)
               c.op = OP_WRITE;
            else if (r < 40)
               c.op = OP_AND;
            else if (r < 62)
               c.op = OP_XOR;
            else if (r < 77) begin
               // Open a clause; this item is its first literal.
               c.op        = OP_CLAUSE;
               clause_left = $urandom_range(0, 5);
               clause_word = c.widx;
               c.last      = (clause_left == 0);
            end else if (r < 86)
               c.op = OP_READ;
            else if (r < 93) begin
               // Refill valid words often, else clause ends drive them to zero.
               c.op = OP_SETVALID;
               if ($urandom_range(0, 1) == 1)
                  c.data = ALL_LANES;
            end else if (r < 96)
               c.op = ($urandom_range(0, 1) == 1) ? OP_SPARE6 : OP_SPARE7;
            else
               c.op = OP_CLAUSE;   // stray literal, last flag left random
         end

         // Never read a lane that has not been written: replace such an
         // item by a full-row write to the row it would have read, and
         // retry any clause literal it displaced.
         need_fix = 1'b0;
         fix_var  = '0;
         if (c.op == OP_READ && !row_full(c.ov, c.widx)) begin
            need_fix = 1'b1;
            fix_var  = c.ov;
         end else if (c.op == OP_AND || c.op == OP_XOR) begin
            if (!row_full(c.av, c.widx)) begin
               need_fix = 1'b1;
               fix_var  = c.av;
            end else if (!row_full(c.bv, c.widx)) begin
               need_fix = 1'b1;
               fix_var  = c.bv;
            end else if ((lane_known[row_addr(c.ov, c.widx)] | c.mask) != ALL_LANES) begin
               need_fix = 1'b1;
               fix_var  = c.ov;
            end
         end else if (c.op == OP_CLAUSE && !row_full(c.av, c.widx)) begin
            need_fix    = 1'b1;
            fix_var     = c.av;
            clause_left = saved_left;
         end
         if (need_fix) begin
            c.op   = OP_WRITE;
            c.ov   = fix_var;
            c.mask = ALL_LANES;
         end

         send_command(c, 1'b0, none);

         // Idle in bursts, except in every third stretch of 40 and in the
         // tail, where items go out back to back.
         quiet = (k >= RANDOM_ITEMS - QUIET_TAIL) || ((k / 40) % 3 == 2);
         if (!quiet && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 18));
         if (k % DRAIN_EVERY == DRAIN_EVERY - 1)
            wait_drained();
      end

      // ---- wind down -------------------------------------------------
      wait_drained();
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
